### rtl/core/qvr_pkg.sv
// types and constants shared by the quaternion vector rotator
package qvr_pkg;

   // operand and intermediate widths
   localparam int QUAT_W  = 16;
   localparam int VEC_W   = 16;
   localparam int PROD_W  = 2 * QUAT_W;          // raw quaternion product
   localparam int COEF_W  = PROD_W + 3;          // matrix entry at scale 2^28
   localparam int TERM_W  = COEF_W + VEC_W;      // entry times vector component
   localparam int SUM_W   = TERM_W;              // three terms still fit
   localparam int FRAC_W  = 28;                  // 1.0 = 2^FRAC_W
   localparam int RND_W   = SUM_W - FRAC_W;      // width after the shift

   // 1.0 and one half at scale 2^28
   localparam logic signed [COEF_W-1:0] ONE_Q28  = COEF_W'(64'sd268435456);
   localparam logic signed [SUM_W-1:0]  HALF_Q28 = SUM_W'(64'sd134217728);

   // rotation direction
   localparam logic CMD_ROTATE  = 1'b0;
   localparam logic CMD_INVERSE = 1'b1;

   // request item
   typedef struct packed {
      logic                     cmd;
      logic signed [QUAT_W-1:0] quat_w;
      logic signed [QUAT_W-1:0] quat_x;
      logic signed [QUAT_W-1:0] quat_y;
      logic signed [QUAT_W-1:0] quat_z;
      logic signed [VEC_W-1:0]  vec_x;
      logic signed [VEC_W-1:0]  vec_y;
      logic signed [VEC_W-1:0]  vec_z;
   } req_type;

   // result item
   typedef struct packed {
      logic signed [VEC_W-1:0] out_x;
      logic signed [VEC_W-1:0] out_y;
      logic signed [VEC_W-1:0] out_z;
      logic                    clipped;
   } rsp_type;

endpackage

### rtl/core/quaternion_vector_rotator_top.sv
// quaternion vector rotator: five stage pipeline from quaternion products to saturated result
// each item passes through the stage 1 to 4 registers and then the result register
// throughput: one item per cycle; every stage takes a new item each cycle unless stalled
// a stall at the result side holds every stage at once, nothing is dropped or repeated
// reset clears the stage valid bits and the result valid; payload registers are not reset
module quaternion_vector_rotator_top
   import qvr_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_item,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_item
);

   // doubled product sign-extended to coefficient width
   function automatic logic signed [COEF_W-1:0] dbl(input logic signed [PROD_W-1:0] p);
      dbl = {{2{p[PROD_W-1]}}, p, 1'b0};
   endfunction

   // pipeline advance: all stages move together
   logic adv;

   // stage 1: quaternion products
   logic                     s1_valid_ff, s1_valid_in;
   logic                     s1_cmd_ff, s1_cmd_in;
   logic signed [VEC_W-1:0]  s1_vec_ff [3];
   logic signed [VEC_W-1:0]  s1_vec_in [3];
   logic signed [PROD_W-1:0] wx_ff, wy_ff, wz_ff, xx_ff, xy_ff, xz_ff, yy_ff, yz_ff, zz_ff;
   logic signed [PROD_W-1:0] wx_in, wy_in, wz_in, xx_in, xy_in, xz_in, yy_in, yz_in, zz_in;
   logic signed [QUAT_W-1:0] q_w, q_x, q_y, q_z;

   // stage 2: selected matrix coefficients
   logic                     s2_valid_ff, s2_valid_in;
   logic signed [VEC_W-1:0]  s2_vec_ff [3];
   logic signed [VEC_W-1:0]  s2_vec_in [3];
   logic signed [COEF_W-1:0] coef_ff [3][3];
   logic signed [COEF_W-1:0] coef_in [3][3];
   logic signed [COEF_W-1:0] mat [3][3];

   // stage 3: coefficient times vector terms
   logic                     s3_valid_ff, s3_valid_in;
   logic signed [TERM_W-1:0] term_ff [3][3];
   logic signed [TERM_W-1:0] term_in [3][3];

   // stage 4: row sums
   logic                     s4_valid_ff, s4_valid_in;
   logic signed [SUM_W-1:0]  sum_ff [3];
   logic signed [SUM_W-1:0]  sum_in [3];

   // stage 5: rounded and saturated result
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_type                  rsp_item_ff, rsp_item_in;
   logic signed [SUM_W-1:0]  rnd [3];
   logic signed [RND_W-1:0]  shifted [3];
   logic signed [VEC_W-1:0]  sat [3];
   logic [2:0]               clip;

   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   // stage 1 next values
   always_comb begin
      q_w          = req_item.quat_w;
      q_x          = req_item.quat_x;
      q_y          = req_item.quat_y;
      q_z          = req_item.quat_z;
      s1_valid_in  = req_valid;
      s1_cmd_in    = req_item.cmd;
      s1_vec_in[0] = req_item.vec_x;
      s1_vec_in[1] = req_item.vec_y;
      s1_vec_in[2] = req_item.vec_z;
      wx_in        = q_w * q_x;
      wy_in        = q_w * q_y;
      wz_in        = q_w * q_z;
      xx_in        = q_x * q_x;
      xy_in        = q_x * q_y;
      xz_in        = q_x * q_z;
      yy_in        = q_y * q_y;
      yz_in        = q_y * q_z;
      zz_in        = q_z * q_z;
   end

   // stage 2 next values: matrix from doubled products, transposed for the inverse
   always_comb begin
      mat[0][0] = ONE_Q28 - dbl(yy_ff) - dbl(zz_ff);
      mat[0][1] = dbl(xy_ff) - dbl(wz_ff);
      mat[0][2] = dbl(xz_ff) + dbl(wy_ff);
      mat[1][0] = dbl(xy_ff) + dbl(wz_ff);
      mat[1][1] = ONE_Q28 - dbl(xx_ff) - dbl(zz_ff);
      mat[1][2] = dbl(yz_ff) - dbl(wx_ff);
      mat[2][0] = dbl(xz_ff) - dbl(wy_ff);
      mat[2][1] = dbl(yz_ff) + dbl(wx_ff);
      mat[2][2] = ONE_Q28 - dbl(xx_ff) - dbl(yy_ff);
      s2_valid_in = s1_valid_ff;
      for (int i = 0; i < 3; i++) begin
         s2_vec_in[i] = s1_vec_ff[i];
         for (int j = 0; j < 3; j++) begin
            coef_in[i][j] = (s1_cmd_ff == CMD_INVERSE) ? mat[j][i] : mat[i][j];
         end
      end
   end

   // stage 3 next values: nine multiplies
   always_comb begin
      s3_valid_in = s2_valid_ff;
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            term_in[i][j] = coef_ff[i][j] * s2_vec_ff[j];
         end
      end
   end

   // stage 4 next values: row sums
   always_comb begin
      s4_valid_in = s3_valid_ff;
      for (int i = 0; i < 3; i++) begin
         sum_in[i] = term_ff[i][0] + term_ff[i][1] + term_ff[i][2];
      end
   end

   // stage 5 next values: round half up, floor shift, saturate
   always_comb begin
      rsp_valid_in = s4_valid_ff;
      for (int i = 0; i < 3; i++) begin
         rnd[i]     = sum_ff[i] + HALF_Q28;
         shifted[i] = rnd[i][SUM_W-1:FRAC_W];
         if (shifted[i][RND_W-1:VEC_W-1] == '0 ||
             shifted[i][RND_W-1:VEC_W-1] == '1) begin
            sat[i]  = shifted[i][VEC_W-1:0];
            clip[i] = 1'b0;
         end else begin
            sat[i]  = shifted[i][RND_W-1] ? {1'b1, {(VEC_W-1){1'b0}}}
                                          : {1'b0, {(VEC_W-1){1'b1}}};
            clip[i] = 1'b1;
         end
      end
      rsp_item_in.out_x   = sat[0];
      rsp_item_in.out_y   = sat[1];
      rsp_item_in.out_z   = sat[2];
      rsp_item_in.clipped = |clip;
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         s3_valid_ff  <= s3_valid_in;
         s4_valid_ff  <= s4_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (adv) begin
         s1_cmd_ff   <= s1_cmd_in;
         wx_ff       <= wx_in;
         wy_ff       <= wy_in;
         wz_ff       <= wz_in;
         xx_ff       <= xx_in;
         xy_ff       <= xy_in;
         xz_ff       <= xz_in;
         yy_ff       <= yy_in;
         yz_ff       <= yz_in;
         zz_ff       <= zz_in;
         for (int i = 0; i < 3; i++) begin
            s1_vec_ff[i] <= s1_vec_in[i];
            s2_vec_ff[i] <= s2_vec_in[i];
            sum_ff[i]    <= sum_in[i];
            for (int j = 0; j < 3; j++) begin
               coef_ff[i][j] <= coef_in[i][j];
               term_ff[i][j] <= term_in[i][j];
            end
         end
         rsp_item_ff <= rsp_item_in;
      end
   end

endmodule
